@@ hdl/assert_macros.svh @@
// Assertion macros shared by the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ hdl/bfiq_pkg.sv @@
// Types and constants of the bloom filter block.
package bfiq_pkg;
  localparam int MAX_FILTER_BITS = 65536;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY  = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [0:0] REG_NUM_PROBES  = 1'b0;
  localparam logic [0:0] REG_FILTER_BITS = 1'b1;
  localparam logic [31:0] HASH_MUL  = 32'hc6a4a793;
  localparam logic [31:0] HASH_SEED = 32'hbc9f1d34;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic conv_step;  // one decimal digit
    logic hash_init;
    logic hash_add;   // add word or tail
    logic hash_mul;
    logic hash_fin;   // xor-shift
    logic probe_init; // h, delta, first modulo
    logic mod_step;   // one bit of the restoring modulo
    logic probe_next; // h += delta
    logic mem_we;     // set probed bit
    logic mem_rd;
    logic mem_chk;    // fold read data
    logic clr_step;
  } bfiq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic conv_done;
    logic last_block;  // no further whole word
    logic tail_only;   // remaining bytes 1..3
    logic no_tail;
    logic mod_done;
    logic clr_done;
  } bfiq_stat_t;
endpackage

@@ hdl/bfiq_ram.sv @@
// Generic single-port RAM with registered read.
module bfiq_ram #(
  parameter int Width = 1,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ hdl/bfiq_ctrl.sv @@
// Sequencer of the bloom filter block.
module bfiq_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [1:0]           command_i,
  input  logic [4:0]           num_probes_i,
  input  bfiq_pkg::bfiq_stat_t stat_i,
  output bfiq_pkg::bfiq_cmd_t  cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);
  localparam logic [3:0] S_IDLE = 4'd0, S_CONV = 4'd1, S_HINIT = 4'd2, S_HADD = 4'd3,
                         S_HMUL = 4'd4, S_HFIN = 4'd5, S_PINIT = 4'd6, S_MOD = 4'd7,
                         S_ACC = 4'd8, S_WAIT = 4'd9, S_CHK = 4'd10, S_CLR = 4'd11,
                         S_NEXT = 4'd12;
  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       tail_q, tail_d;
  logic [4:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      op_q    <= bfiq_pkg::CMD_CLEAR;
      tail_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    tail_d  = tail_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = command_i;
          cmd_o.load = 1'b1;
          priority if (command_i == bfiq_pkg::CMD_CLEAR) state_d = S_CLR;
          else if (command_i == bfiq_pkg::CMD_INSERT || command_i == bfiq_pkg::CMD_QUERY)
            state_d = S_CONV;
          else state_d = S_IDLE;
        end
      end
      S_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_done) state_d = S_HINIT;
      end
      S_HINIT: begin
        cmd_o.hash_init = 1'b1;
        tail_d  = 1'b0;
        state_d = S_HADD;
      end
      S_HADD: begin
        // a word, or the tail once no whole word is left
        priority if (stat_i.last_block && stat_i.no_tail) state_d = S_PINIT;
        else begin
          cmd_o.hash_add = 1'b1;
          tail_d  = stat_i.tail_only;
          state_d = S_HMUL;
        end
      end
      S_HMUL: begin
        cmd_o.hash_mul = 1'b1;
        state_d = S_HFIN;
      end
      S_HFIN: begin
        cmd_o.hash_fin = 1'b1;
        state_d = tail_q ? S_PINIT : S_HADD;
      end
      S_PINIT: begin
        cmd_o.probe_init = 1'b1;
        cnt_d   = num_probes_i;
        state_d = S_MOD;
      end
      S_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (stat_i.mod_done) state_d = S_ACC;
      end
      S_ACC: begin
        if (op_q == bfiq_pkg::CMD_INSERT) begin
          cmd_o.mem_we = 1'b1;
          state_d = S_NEXT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d = S_WAIT;
        end
      end
      S_WAIT: state_d = S_CHK;
      S_CHK: begin
        cmd_o.mem_chk = 1'b1;
        state_d = S_NEXT;
      end
      S_NEXT: begin
        cmd_o.probe_next = 1'b1;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          done_o  = (op_q == bfiq_pkg::CMD_QUERY);
          state_d = S_IDLE;
        end else state_d = S_MOD;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_done) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
endmodule

@@ hdl/bfiq_dp.sv @@
// Datapath: decimal text, hash, probe modulo and bit store.
module bfiq_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [31:0]          key_i,
  input  logic [16:0]          filter_bits_i,
  input  bfiq_pkg::bfiq_cmd_t  cmd_i,
  output bfiq_pkg::bfiq_stat_t stat_o,
  output logic                 found_o
);
  localparam int MaxFilterBits = bfiq_pkg::MAX_FILTER_BITS;
  localparam int AW = $clog2(MaxFilterBits);

  // text buffer, most significant char in byte 0
  logic [7:0]  txt_q [11];
  logic [7:0]  txt_d [11];
  logic [31:0] mag_q;
  logic        neg_q;
  logic [3:0]  nd_q;      // digits produced
  logic [3:0]  len;
  logic [3:0]  pos_q;     // hash byte offset
  logic [31:0] h_q, acc_q, delta_q;
  logic [63:0] prod;
  logic [16:0] rem_q;
  logic [5:0]  bit_q;
  logic [AW-1:0] clr_q;
  logic        all_q;
  logic        clr_done_q;
  logic [31:0] mag_div;
  logic [3:0]  mag_rem;
  logic [63:0] recip;
  logic [17:0] trial;
  logic        rdata, we;
  logic [AW-1:0] addr;
  logic [3:0]  left;
  logic [31:0] word;

  // divide by ten by reciprocal
  assign recip   = {32'd0, mag_q} * 64'hcccccccd;
  assign mag_div = {3'd0, recip[63:35]};
  assign mag_rem = 4'(mag_q - mag_div * 32'd10);

  assign len  = nd_q + {3'd0, neg_q};
  assign left = len - pos_q;

  // digits are produced least significant first; shift text up by one each step
  always_comb begin
    for (int i = 0; i < 11; i++) txt_d[i] = txt_q[i];
    if (cmd_i.conv_step) begin
      for (int i = 10; i > 0; i--) txt_d[i] = txt_q[i-1];
      txt_d[0] = 8'h30 + {4'd0, mag_rem};
    end
  end

  function automatic logic [7:0] text_at(input logic [3:0] p);
    logic [7:0] c;
    logic [3:0] k;
    c = 8'h2d;
    if (!(neg_q && p == 4'd0)) begin
      k = p - {3'd0, neg_q};
      c = (k < nd_q) ? txt_q[k] : 8'h00;
    end
    return c;
  endfunction

  always_comb begin
    word = '0;
    for (int b = 0; b < 4; b++)
      if (4'(b) < left) word[8*b+:8] = text_at(pos_q + 4'(b));
  end

  assign prod  = {32'd0, acc_q} * {32'd0, bfiq_pkg::HASH_MUL};
  assign trial = {rem_q, h_q[bit_q[4:0]]} - {1'b0, filter_bits_i};

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 11; i++) txt_q[i] <= txt_d[i];
    if (cmd_i.load) begin
      neg_q <= key_i[31];
      mag_q <= key_i[31] ? (32'd0 - key_i) : key_i;
      nd_q  <= '0;
      all_q <= 1'b1;
    end
    if (cmd_i.conv_step) begin
      mag_q <= mag_div;
      nd_q  <= nd_q + 4'd1;
    end
    if (cmd_i.hash_init) begin
      acc_q <= bfiq_pkg::HASH_SEED ^ 32'(32'(len) * bfiq_pkg::HASH_MUL);
      pos_q <= '0;
    end
    if (cmd_i.hash_add) begin
      acc_q <= acc_q + word;
      pos_q <= pos_q + 4'd4;
    end
    if (cmd_i.hash_mul) acc_q <= prod[31:0];
    // offset past the text end marks the tail round
    if (cmd_i.hash_fin) acc_q <= acc_q ^ (acc_q >> ((pos_q > len) ? 5'd24 : 5'd16));
    if (cmd_i.probe_init) begin
      h_q     <= acc_q;
      delta_q <= {acc_q[16:0], acc_q[31:17]};
      rem_q   <= '0;
      bit_q   <= 6'd31;
    end
    if (cmd_i.mod_step) begin
      rem_q <= trial[17] ? {rem_q[15:0], h_q[bit_q[4:0]]} : trial[16:0];
      bit_q <= bit_q - 6'd1;
    end
    if (cmd_i.probe_next) begin
      h_q   <= h_q + delta_q;
      rem_q <= '0;
      bit_q <= 6'd31;
    end
    if (cmd_i.mem_chk && !rdata) all_q <= 1'b0;
  end

  // clear sweep address; the sweep also runs straight out of reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.load) begin
      clr_q      <= '0;
      clr_done_q <= 1'b0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + AW'(1);
      if (clr_q == AW'(MaxFilterBits - 1)) clr_done_q <= 1'b1;
    end
  end

  assign we   = cmd_i.mem_we || cmd_i.clr_step;
  assign addr = cmd_i.clr_step ? clr_q : rem_q[AW-1:0];

  bfiq_ram #(.Width(1), .Depth(MaxFilterBits)) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(!cmd_i.clr_step),
    .rdata_o(rdata)
  );

  assign stat_o.conv_done  = (mag_div == 32'd0) || (nd_q == 4'd9);
  assign stat_o.last_block = (left < 4'd4);
  assign stat_o.tail_only  = (left < 4'd4);
  assign stat_o.no_tail    = (left == 4'd0) || (pos_q > len);
  assign stat_o.mod_done   = (bit_q == 6'd0);
  assign stat_o.clr_done   = clr_done_q || (clr_q == AW'(MaxFilterBits - 1));
  assign found_o = all_q && !(cmd_i.mem_chk && !rdata);
endmodule

@@ hdl/bloom_filter_insert_query_top.sv @@
// Top level of the bloom filter insert and query block.
//
//  channel  | ports                               | handshake
//  request  | start_i, command_i, key_i           | start_i && !busy_o
//  result   | found_o                             | done_o, one cycle, no stall
//  config   | cfg_we_i, cfg_index_i, cfg_wdata_i  | cfg_we_i
//
// Insert/query: the request is accepted, the key is converted to decimal text
// digit by digit, the text is hashed and the probes are set up; then each probe
// runs a bit-serial restoring remainder and a store write (insert) or a store
// read and check (query).
// Clear and reset sweep all MAX_FILTER_BITS bits of the store one bit a cycle,
// busy_o high throughout. The result cannot be stalled.
`include "assert_macros.svh"
module bloom_filter_insert_query_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  command_i,
  input  logic signed [31:0] key_i,
  output logic        busy_o,
  output logic        done_o,
  output logic        found_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [16:0] cfg_wdata_i
);
  logic [4:0]  num_probes_q;
  logic [16:0] filter_bits_q;
  bfiq_pkg::bfiq_cmd_t  cmd;
  bfiq_pkg::bfiq_stat_t stat;
  logic [16:0] fb_clamped;
  localparam logic [16:0] MaxFb = 17'(bfiq_pkg::MAX_FILTER_BITS);

  // filter size clamped to 8..MAX, then multiple of eight
  always_comb begin
    fb_clamped = cfg_wdata_i;
    if (fb_clamped < 17'd8) fb_clamped = 17'd8;
    if (fb_clamped > MaxFb) fb_clamped = MaxFb;
    fb_clamped = fb_clamped & ~17'd7;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_probes_q  <= 5'd6;
      filter_bits_q <= MaxFb;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bfiq_pkg::REG_NUM_PROBES:
          num_probes_q <= (cfg_wdata_i == 17'd0) ? 5'd1 :
                          (cfg_wdata_i > 17'd30) ? 5'd30 : cfg_wdata_i[4:0];
        bfiq_pkg::REG_FILTER_BITS: filter_bits_q <= fb_clamped;
        default: ;
      endcase
    end
  end

  bfiq_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .command_i,
    .num_probes_i(num_probes_q), .stat_i(stat), .cmd_o(cmd), .busy_o, .done_o
  );

  bfiq_dp u_dp (
    .clk_i, .rst_ni, .key_i(key_i), .filter_bits_i(filter_bits_q),
    .cmd_i(cmd), .stat_o(stat), .found_o
  );

  `ASSERT_IMPL(a_done_busy, clk_i, rst_ni, done_o, busy_o, "result outside a request")
  `ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "busy after result")
  `ASSERT_IMPL(a_probes_rng, clk_i, rst_ni, 1'b1,
               num_probes_q != 5'd0 && num_probes_q <= 5'd30, "probe count out of range")
endmodule

@@ sim/bloom_filter_insert_query_top_tb.sv @@
// Self-checking testbench for the bloom filter insert and query block.
`timescale 1ns / 100ps
module bloom_filter_insert_query_top_tb;

  localparam int          STORE_BITS  = bfiq_pkg::MAX_FILTER_BITS;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;  // ignored by the block
  localparam int          DOG_LIMIT   = 300000; // longer than a full clear sweep
  localparam int          SETTLE_WAIT = 1500;   // beyond the longest 30-probe request

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  command_i = bfiq_pkg::CMD_INSERT;
  logic signed [31:0] key_i = '0;
  logic        busy_o, done_o, found_o;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_index_i = bfiq_pkg::REG_NUM_PROBES;
  logic [16:0] cfg_wdata_i = '0;

  bloom_filter_insert_query_top DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the filter: its own bit store and register copies
  logic        shadow_store [STORE_BITS];
  logic [31:0] probes_now;
  logic [31:0] bits_now;
  logic        found_queue [$];   // expected query answers, oldest first
  int          fail_count = 0;
  int          requests_sent = 0;
  int          queries_seen = 0;
  int          hits_seen = 0;
  bit          idling_on = 1'b1;
  int          dog_count = 0;

  // Murmur-like hash over the decimal text of the key
  function automatic logic [31:0] key_text_hash(logic [31:0] raw);
    logic [7:0]  txt [12];
    logic [7:0]  digs [10];
    logic [31:0] mag, h, w;
    int          nd, len, i;
    nd = 0; len = 0; mag = raw;
    if (raw[31]) begin
      txt[len++] = "-";
      mag = 32'd0 - raw;
    end
    do begin
      digs[nd++] = 8'd48 + 8'(mag % 10);
      mag = mag / 10;
    end while (mag != 0 && nd < 10);
    while (nd > 0) txt[len++] = digs[--nd];
    h = bfiq_pkg::HASH_SEED ^ (32'(len) * bfiq_pkg::HASH_MUL);
    i = 0;
    while (i + 4 <= len) begin
      w = {txt[i+3], txt[i+2], txt[i+1], txt[i]};
      i += 4;
      h = (h + w) * bfiq_pkg::HASH_MUL;
      h ^= h >> 16;
    end
    if (len - i > 0) begin
      if (len - i == 3) h += {8'd0, txt[i+2], 16'd0};
      if (len - i >= 2) h += {16'd0, txt[i+1], 8'd0};
      h = (h + {24'd0, txt[i]}) * bfiq_pkg::HASH_MUL;
      h ^= h >> 24;
    end
    return h;
  endfunction

  // Apply one accepted request to the shadow; queue an answer for queries
  task automatic filter_apply(logic [1:0] cmd, logic [31:0] key);
    logic [31:0] h, delta, pos;
    logic        all_set;
    all_set = 1'b1;
    if (cmd == bfiq_pkg::CMD_CLEAR) begin
      foreach (shadow_store[i]) shadow_store[i] = 1'b0;
    end else if (cmd != CMD_UNUSED) begin
      h = key_text_hash(key);
      delta = {h[16:0], h[31:17]};
      for (int j = 0; j < probes_now; j++) begin
        pos = h % bits_now;
        if (cmd == bfiq_pkg::CMD_INSERT) shadow_store[pos] = 1'b1;
        else if (!shadow_store[pos]) all_set = 1'b0;
        h += delta;
      end
      if (cmd == bfiq_pkg::CMD_QUERY) found_queue.push_back(all_set);
    end
  endtask

  // One request; start stays high if the caller sends straight on
  task automatic send_request(logic [1:0] cmd, logic [31:0] key);
    if (idling_on && $urandom_range(3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    do @(posedge clk_i); while (busy_o);
    filter_apply(cmd, key);
    requests_sent++;
  endtask

  // Hold off until every answer is in and the block has settled
  task automatic drain_filter();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (found_queue.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [16:0] val);
    drain_filter();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == bfiq_pkg::REG_NUM_PROBES) begin
      probes_now = (val < 1) ? 1 : (val > 30) ? 30 : val;
    end else begin
      bits_now = (val < 8) ? 8 : (val > STORE_BITS) ? STORE_BITS : val;
      bits_now &= ~32'd7;
    end
  endtask

  // Answer checker: done_o is a single-cycle strobe with no back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (found_queue.size() == 0) begin
        $error("found: unexpected answer %0b", found_o);
        fail_count++;
      end else begin
        logic exp_found;
        exp_found = found_queue.pop_front();
        queries_seen++;
        hits_seen += exp_found;
        if (found_o !== exp_found) begin
          $error("found: expected %0b, actual %0b", exp_found, found_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no request, answer or register write
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) dog_count <= 0;
    else dog_count <= dog_count + 1;
    if (dog_count >= DOG_LIMIT) begin
      $display("bloom_filter_insert_query_top: mismatch");
      $finish;
    end
  end

  // Edge keys (text lengths 1 to 5, 9, 10 and 11), command 3 and a clear
  task automatic test_directed();
    logic [31:0] keys [10] = '{32'd0, 32'hffffffff, 32'd9, 32'd10, 32'd1234, 32'd12345,
                               32'd2147483647, 32'h80000000, 32'hfffffff4, 32'd999999999};
    write_reg(bfiq_pkg::REG_NUM_PROBES, 17'd0);      // clamps up to one
    write_reg(bfiq_pkg::REG_FILTER_BITS, 17'd0);     // clamps up to eight
    send_request(bfiq_pkg::CMD_QUERY, keys[0]);
    send_request(bfiq_pkg::CMD_INSERT, keys[0]);
    send_request(bfiq_pkg::CMD_QUERY, keys[0]);
    write_reg(bfiq_pkg::REG_NUM_PROBES, 17'h1ffff);  // clamps down to thirty
    write_reg(bfiq_pkg::REG_FILTER_BITS, 17'h1ffff); // clamps to full store
    foreach (keys[i]) send_request(bfiq_pkg::CMD_INSERT, keys[i]);
    foreach (keys[i]) send_request(bfiq_pkg::CMD_QUERY, keys[i]);
    send_request(CMD_UNUSED, keys[1]);
    send_request(bfiq_pkg::CMD_QUERY, 32'd77);
    send_request(bfiq_pkg::CMD_CLEAR, 32'hffffffff);
    send_request(bfiq_pkg::CMD_QUERY, keys[6]);
  endtask

  // Random mix over a small key pool so queries often hit
  task automatic test_random_phase(logic [16:0] probes, logic [16:0] bits, int count,
                                   bit with_clear);
    logic [31:0] pool [24];
    logic [31:0] k;
    int          r;
    write_reg(bfiq_pkg::REG_NUM_PROBES, probes);
    write_reg(bfiq_pkg::REG_FILTER_BITS, bits);
    foreach (pool[i]) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      k = ($urandom_range(9) < 7) ? pool[$urandom_range(23)] : $urandom;
      r = $urandom_range(99);
      if (with_clear && n == count / 2) send_request(bfiq_pkg::CMD_CLEAR, k);
      else if (r < 45) send_request(bfiq_pkg::CMD_INSERT, k);
      else if (r < 95) send_request(bfiq_pkg::CMD_QUERY, k);
      else send_request(CMD_UNUSED, k);
      if (n == count / 3) drain_filter();   // sender waits for every answer once
    end
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 1'b0;
    probes_now = 6;
    bits_now   = STORE_BITS;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(17'd6, 17'd65536, 150, 1'b0);
    test_random_phase(17'd1, 17'd8, 150, 1'b0);
    test_random_phase(17'd30, 17'd203, 130, 1'b1);   // rounds down to 200
    test_random_phase(17'd17, 17'd1000, 150, 1'b0);
    test_random_phase(17'd3, 17'd64, 150, 1'b0);
    idling_on = 1'b0;                                 // back-to-back tail
    test_random_phase(17'd12, 17'd4096, 200, 1'b0);

    drain_filter();
    $display("Covered %0d requests, %0d query answers (%0d hits), across several settings",
             requests_sent, queries_seen, hits_seen);
    $display("of probe count and filter size, including clamped register values.");
    if (fail_count == 0 && found_queue.size() == 0) begin
      $display("bloom_filter_insert_query_top: match");
    end else begin
      $display("bloom_filter_insert_query_top: mismatch");
    end
    $finish;
  end
endmodule
